// ===== hdl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked assertion, live during reset as well.
`define CEFU_ASSERT(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

// Clocked assertion, off while reset is high.
`define CEFU_ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

// ===== hdl/cefu_pkg.sv =====
package cefu_pkg;

   localparam int SAMPLE_BITS_DEF = 16;
   localparam int MAX_SAMPLES     = 4096;
   localparam int INDEX_BITS      = 13;
   localparam int LEN_BITS        = 13;
   localparam int THR_BITS        = 15;
   localparam int POS_BITS        = 32;
   localparam int STRENGTH_BITS   = 16;
   localparam int FRAC_BITS       = 16;
   localparam int DIV_NUM_BITS    = 64;
   localparam int CSR_INDEX_BITS  = 3;
   localparam int CSR_DATA_BITS   = 32;
   localparam int RSP_DATA_BITS   = STRENGTH_BITS + POS_BITS;
   localparam int QUEUE_DEPTH     = 4;
   // job word: p, d, index, strength, falling
   localparam int JOB_FIXED_BITS  = 3 + INDEX_BITS + STRENGTH_BITS + 1;

   localparam logic [1:0] PM_BOTH      = 2'd0;
   localparam logic [1:0] PM_RISE_ONLY = 2'd1;
   localparam logic [1:0] PM_FALL_ONLY = 2'd2;
   localparam logic SCAN_REVERSE = 1'b1;
   localparam logic KIND_RISE    = 1'b0;
   localparam logic KIND_FALL    = 1'b1;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_THRESHOLD,
      CSR_POLARITY,
      CSR_BACKWARD,
      CSR_LENGTH,
      CSR_RANGE_START,
      CSR_RANGE_END
   } csr_index_type;

   typedef struct packed {
      logic [THR_BITS-1:0]        threshold;
      logic [1:0]                 polarity;
      logic                       backward;
      logic [LEN_BITS-1:0]        length;
      logic signed [POS_BITS-1:0] range_start;
      logic signed [POS_BITS-1:0] range_end;
   } cfg_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_FRAC_GO,
      BK_FRAC_WAIT,
      BK_MUL_LO,
      BK_MUL_HI,
      BK_MUL_SUM,
      BK_QUO_GO,
      BK_QUO_WAIT,
      BK_FINISH
   } back_state_type;

endpackage

// ===== hdl/caliper_extremum_edge_finder_unit.sv =====
// Caliper edge finder: takes a derivative profile one request per cycle and reports each
// rising edge (local maximum above the threshold) and falling edge (local minimum below
// minus the threshold) with its strength and a subsample Q16.16 position mapped into the
// configured range. The front end classifies each sample combinationally and accepts one
// request per clock whenever its four-entry edge queue has room. Each edge then takes two
// passes of the shared bit-serial divider in the back end (subsample shift, then scaling
// by the profile length) plus a split multiply and rounding. Edges that arrive faster than
// the back end finishes them fill the queue and drop req_tready until it drains. The user
// must write configuration through the csr port while no request is in flight; the block
// does not enforce this. Reset needs no clearing pass.
module caliper_extremum_edge_finder_unit #(
   parameter int SAMPLE_BITS = cefu_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       req_tdata,  // sample
   input  logic                                   req_tuser,  // profile_start
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [cefu_pkg::RSP_DATA_BITS-1:0]     rsp_tdata,  // edge_strength, edge_position
   output logic                                   rsp_tuser,  // edge_falling
   input  logic                                   csr_we,
   input  logic [cefu_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [cefu_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);
   import cefu_pkg::*;

   localparam int JOB_BITS = 2 * SAMPLE_BITS + JOB_FIXED_BITS;

   logic [THR_BITS-1:0]        thr_ff, thr_in;
   logic [1:0]                 pol_ff, pol_in;
   logic                       bwd_ff, bwd_in;
   logic [LEN_BITS-1:0]        len_ff, len_in;
   logic signed [POS_BITS-1:0] rstart_ff, rstart_in, rend_ff, rend_in;

   cfg_type                  cfg;
   logic [LEN_BITS-1:0]      len_eff;
   logic                     q_full, q_empty, q_push, q_pop;
   logic [JOB_BITS-1:0]      q_wdata, q_rdata;
   logic [STRENGTH_BITS-1:0] rsp_strength;
   logic [POS_BITS-1:0]      rsp_position;

   always_comb begin
      thr_in    = thr_ff;
      pol_in    = pol_ff;
      bwd_in    = bwd_ff;
      len_in    = len_ff;
      rstart_in = rstart_ff;
      rend_in   = rend_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_THRESHOLD:   thr_in    = csr_wdata[THR_BITS-1:0];
            CSR_POLARITY:    pol_in    = csr_wdata[1:0];
            CSR_BACKWARD:    bwd_in    = csr_wdata[0];
            CSR_LENGTH:      len_in    = csr_wdata[LEN_BITS-1:0];
            CSR_RANGE_START: rstart_in = $signed(csr_wdata[POS_BITS-1:0]);
            CSR_RANGE_END:   rend_in   = $signed(csr_wdata[POS_BITS-1:0]);
            default:         ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff    <= '0;
         pol_ff    <= PM_BOTH;
         bwd_ff    <= 1'b0;
         len_ff    <= LEN_BITS'(MAX_SAMPLES);
         rstart_ff <= '0;
         rend_ff   <= POS_BITS'(1) << FRAC_BITS;
      end else begin
         thr_ff    <= thr_in;
         pol_ff    <= pol_in;
         bwd_ff    <= bwd_in;
         len_ff    <= len_in;
         rstart_ff <= rstart_in;
         rend_ff   <= rend_in;
      end
   end

   always_comb begin
      if (len_ff == '0) begin
         len_eff = LEN_BITS'(1);
      end else if (int'(len_ff) > MAX_SAMPLES) begin
         len_eff = LEN_BITS'(MAX_SAMPLES);
      end else begin
         len_eff = len_ff;
      end
      cfg.threshold   = thr_ff;
      cfg.polarity    = pol_ff;
      cfg.backward    = bwd_ff;
      cfg.length      = len_eff;
      cfg.range_start = rstart_ff;
      cfg.range_end   = rend_ff;
   end

   cefu_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_sample ($signed(req_tdata[SAMPLE_BITS-1:0])),
      .req_start  (req_tuser),
      .queue_full (q_full),
      .push       (q_push),
      .push_data  (q_wdata)
   );

   cefu_fifo #(.WIDTH(JOB_BITS), .DEPTH(QUEUE_DEPTH)) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .pop       (q_pop),
      .full      (q_full),
      .empty     (q_empty),
      .pop_data  (q_rdata)
   );

   cefu_back #(.SAMPLE_BITS(SAMPLE_BITS)) u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .job_valid    (!q_empty),
      .job_data     (q_rdata),
      .job_pop      (q_pop),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_strength (rsp_strength),
      .rsp_position (rsp_position),
      .rsp_falling  (rsp_tuser)
   );

   assign rsp_tdata = {rsp_position, rsp_strength};

endmodule

// ===== hdl/cefu_fifo.sv =====
module cefu_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = cefu_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             full,
   output logic             empty,
   output logic [WIDTH-1:0] pop_data
);
   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    mem_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;

   assign full     = (count_ff == CNT_BITS'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_BITS'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_BITS'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hdl/cefu_front.sv =====
module cefu_front #(
   parameter int SAMPLE_BITS = cefu_pkg::SAMPLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cefu_pkg::cfg_type             cfg,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  logic                          req_start,
   input  logic                          queue_full,
   output logic                          push,
   output logic [2*SAMPLE_BITS+cefu_pkg::JOB_FIXED_BITS-1:0] push_data
);
   import cefu_pkg::*;

   localparam int P_BITS   = SAMPLE_BITS + 1;
   localparam int D_BITS   = SAMPLE_BITS + 2;
   localparam int CMP_BITS = (SAMPLE_BITS > 16) ? SAMPLE_BITS : 16;
   localparam int ST_BITS  = (P_BITS > STRENGTH_BITS + 1) ? P_BITS : STRENGTH_BITS + 1;

   logic signed [SAMPLE_BITS-1:0] cur_ff, cur_in, prev_ff, prev_in;
   logic signed [INDEX_BITS-1:0]  idx_ff, idx_in;
   logic signed [1:0]             rise_ff, rise_in, drop_ff, drop_in;

   logic                          accept, lt, rise_edge, fall_edge;
   logic                          rising_ok, falling_ok;
   logic signed [SAMPLE_BITS-1:0] cur_eff, prev_eff;
   logic signed [1:0]             rise_eff, drop_eff;
   logic signed [CMP_BITS-1:0]    cur_ext, thr_pos, thr_neg;
   logic signed [P_BITS-1:0]      p_w, oth_w, mag_w;
   logic signed [D_BITS-1:0]      d_w;
   logic [ST_BITS-1:0]            mag_u;
   logic [STRENGTH_BITS-1:0]      strength_w;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      cur_eff    = req_start ? '0 : cur_ff;
      prev_eff   = req_start ? '0 : prev_ff;
      rise_eff   = req_start ? 2'sb11 : rise_ff;
      drop_eff   = req_start ? 2'sb11 : drop_ff;
      rising_ok  = (cfg.polarity != PM_FALL_ONLY);
      falling_ok = (cfg.polarity != PM_RISE_ONLY);
      cur_ext    = CMP_BITS'(cur_eff);
      thr_pos    = $signed(CMP_BITS'(cfg.threshold));
      thr_neg    = -thr_pos;
      lt         = (req_sample < cur_eff);
      rise_edge  = lt && rising_ok && (rise_eff == 2'sd1) && (cur_ext > thr_pos);
      fall_edge  = !lt && falling_ok && (drop_eff == 2'sd1) && (cur_ext < thr_neg);

      if (lt) begin
         p_w   = P_BITS'(cur_eff) - P_BITS'(prev_eff);
         oth_w = P_BITS'(cur_eff) - P_BITS'(req_sample);
         mag_w = P_BITS'(cur_eff);
      end else begin
         p_w   = P_BITS'(prev_eff) - P_BITS'(cur_eff);
         oth_w = P_BITS'(req_sample) - P_BITS'(cur_eff);
         mag_w = -P_BITS'(cur_eff);
      end
      d_w        = D_BITS'(p_w) + D_BITS'(oth_w);
      mag_u      = ST_BITS'($unsigned(mag_w));
      strength_w = (mag_u > ST_BITS'({STRENGTH_BITS{1'b1}})) ? {STRENGTH_BITS{1'b1}}
                                                             : mag_u[STRENGTH_BITS-1:0];

      push      = accept && (rise_edge || fall_edge);
      push_data = {(fall_edge ? KIND_FALL : KIND_RISE), strength_w, idx_ff, d_w, p_w};

      if (lt) begin
         rise_in = 2'sd0;
         drop_in = (drop_eff < 2'sd1) ? drop_eff + 2'sd1 : drop_eff;
      end else begin
         rise_in = (rise_eff < 2'sd1) ? rise_eff + 2'sd1 : rise_eff;
         drop_in = 2'sd0;
      end

      if (req_start || (idx_ff == '1)) begin
         idx_in = (cfg.backward == SCAN_REVERSE) ? $signed(cfg.length - LEN_BITS'(1)) : '0;
      end else if (cfg.backward == SCAN_REVERSE) begin
         idx_in = idx_ff - INDEX_BITS'(1);
      end else begin
         idx_in = idx_ff + INDEX_BITS'(1);
      end
      prev_in = cur_eff;
      cur_in  = req_sample;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff  <= '0;
         prev_ff <= '0;
         idx_ff  <= '1;
         rise_ff <= 2'sb11;
         drop_ff <= 2'sb11;
      end else if (accept) begin
         cur_ff  <= cur_in;
         prev_ff <= prev_in;
         idx_ff  <= idx_in;
         rise_ff <= rise_in;
         drop_ff <= drop_in;
      end
   end

endmodule

// ===== hdl/cefu_div.sv =====
module cefu_div #(
   parameter int DEN_BITS = cefu_pkg::LEN_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [cefu_pkg::DIV_NUM_BITS-1:0]  numer,
   input  logic [DEN_BITS-1:0]                denom,
   output logic                               done,
   output logic [cefu_pkg::DIV_NUM_BITS-1:0]  quotient
);
   import cefu_pkg::*;

   localparam int CNT_BITS = $clog2(DIV_NUM_BITS);

   logic                    busy_ff, busy_in, done_ff, done_in;
   logic [CNT_BITS-1:0]     count_ff, count_in;
   logic [DEN_BITS-1:0]     rem_ff, rem_in, den_ff, den_in;
   logic [DIV_NUM_BITS-1:0] quo_ff, quo_in;
   logic [DEN_BITS:0]       rem_sh, rem_diff;
   logic                    ge;

   assign done     = done_ff;
   assign quotient = quo_ff;

   always_comb begin
      rem_sh   = {rem_ff, quo_ff[DIV_NUM_BITS-1]};
      ge       = (rem_sh >= {1'b0, den_ff});
      rem_diff = rem_sh - {1'b0, den_ff};
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      quo_in   = quo_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = '0;
         den_in   = denom;
         quo_in   = numer;
      end else if (busy_ff) begin
         quo_in   = {quo_ff[DIV_NUM_BITS-2:0], ge};
         rem_in   = ge ? rem_diff[DEN_BITS-1:0] : rem_sh[DEN_BITS-1:0];
         count_in = count_ff + CNT_BITS'(1);
         if (count_ff == CNT_BITS'(DIV_NUM_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

endmodule

// ===== hdl/cefu_back.sv =====
module cefu_back #(
   parameter int SAMPLE_BITS = cefu_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  cefu_pkg::cfg_type                    cfg,
   input  logic                                 job_valid,
   input  logic [2*SAMPLE_BITS+cefu_pkg::JOB_FIXED_BITS-1:0] job_data,
   output logic                                 job_pop,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [cefu_pkg::STRENGTH_BITS-1:0]   rsp_strength,
   output logic [cefu_pkg::POS_BITS-1:0]        rsp_position,
   output logic                                 rsp_falling
);
   import cefu_pkg::*;

   localparam int P_BITS       = SAMPLE_BITS + 1;
   localparam int D_BITS       = SAMPLE_BITS + 2;
   localparam int DEN_BITS     = (D_BITS > LEN_BITS) ? D_BITS : LEN_BITS;
   localparam int T_BITS       = INDEX_BITS + FRAC_BITS + 1;
   localparam int SPAN_BITS    = POS_BITS + 1;
   localparam int SPAN_LO_BITS = SPAN_BITS / 2;
   localparam int SPAN_HI_BITS = SPAN_BITS - SPAN_LO_BITS;
   localparam int PROD_BITS    = SPAN_HI_BITS + T_BITS;
   localparam int ACC_BITS     = DIV_NUM_BITS;
   localparam int R_BITS       = DIV_NUM_BITS + 2;
   localparam logic signed [R_BITS-1:0] POS_MAX =
      $signed({{(R_BITS-POS_BITS+1){1'b0}}, {(POS_BITS-1){1'b1}}});
   localparam logic signed [R_BITS-1:0] POS_MIN =
      $signed({{(R_BITS-POS_BITS+1){1'b1}}, {(POS_BITS-1){1'b0}}});
   localparam logic [DIV_NUM_BITS-1:0] FRAC_ONE = DIV_NUM_BITS'(1) << FRAC_BITS;

   back_state_type state_ff, state_in;

   logic div_start, div_sel_quo, load_frac, mul_lo, mul_hi, mul_sum, load_out, out_free;
   logic div_done;
   logic [DIV_NUM_BITS-1:0] div_numer, div_quotient;
   logic [DEN_BITS-1:0]     div_denom;

   logic signed [P_BITS-1:0]    p_ff, p_in;
   logic signed [D_BITS-1:0]    d_ff, d_in;
   logic signed [INDEX_BITS-1:0] idx_ff, idx_in;
   logic [STRENGTH_BITS-1:0]    st_ff, st_in;
   logic                        fall_ff, fall_in;
   logic                        span_neg_ff, span_neg_in;
   logic [SPAN_BITS-1:0]        span_mag_ff, span_mag_in;
   logic                        neg_ff, neg_in;
   logic [T_BITS-1:0]           t_mag_ff, t_mag_in;
   logic [PROD_BITS-1:0]        prod_ff, prod_in;
   logic [ACC_BITS-1:0]         acc_ff, acc_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [STRENGTH_BITS-1:0]    out_st_ff, out_st_in;
   logic [POS_BITS-1:0]         out_pos_ff, out_pos_in;
   logic                        out_fall_ff, out_fall_in;

   logic signed [SPAN_BITS-1:0] span_w;
   logic [SAMPLE_BITS-1:0]      p_u;
   logic                        d_pos;
   logic [FRAC_BITS:0]          frac_w;
   logic signed [T_BITS-1:0]    t_w;
   logic [SPAN_HI_BITS-1:0]     mul_a;
   logic [PROD_BITS-1:0]        prod_w;
   logic [ACC_BITS-1:0]         rnd_w;
   logic signed [R_BITS-1:0]    rs_w, qq_w, r_w;

   cefu_div #(.DEN_BITS(DEN_BITS)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (div_numer),
      .denom    (div_denom),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_strength = out_st_ff;
   assign rsp_position = out_pos_ff;
   assign rsp_falling  = out_fall_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE:      if (job_valid) state_in = BK_FRAC_GO;
         BK_FRAC_GO:   state_in = BK_FRAC_WAIT;
         BK_FRAC_WAIT: if (div_done) state_in = BK_MUL_LO;
         BK_MUL_LO:    state_in = BK_MUL_HI;
         BK_MUL_HI:    state_in = BK_MUL_SUM;
         BK_MUL_SUM:   state_in = BK_QUO_GO;
         BK_QUO_GO:    state_in = BK_QUO_WAIT;
         BK_QUO_WAIT:  if (div_done) state_in = BK_FINISH;
         BK_FINISH:    if (out_free) state_in = BK_IDLE;
         default:      state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      job_pop     = 1'b0;
      div_start   = 1'b0;
      div_sel_quo = 1'b0;
      load_frac   = 1'b0;
      mul_lo      = 1'b0;
      mul_hi      = 1'b0;
      mul_sum     = 1'b0;
      load_out    = 1'b0;
      case (state_ff)
         BK_IDLE:      job_pop = job_valid;
         BK_FRAC_GO:   div_start = 1'b1;
         BK_FRAC_WAIT: load_frac = div_done;
         BK_MUL_LO:    mul_lo = 1'b1;
         BK_MUL_HI:    mul_hi = 1'b1;
         BK_MUL_SUM:   mul_sum = 1'b1;
         BK_QUO_GO: begin
            div_start   = 1'b1;
            div_sel_quo = 1'b1;
         end
         BK_QUO_WAIT:  ;
         BK_FINISH:    load_out = out_free;
         default:      ;
      endcase
   end

   always_comb begin
      p_u       = p_ff[P_BITS-1] ? '0 : p_ff[SAMPLE_BITS-1:0];
      d_pos     = !d_ff[D_BITS-1] && (d_ff != '0);
      rnd_w     = acc_ff + ACC_BITS'({cfg.length, {(FRAC_BITS-1){1'b0}}});
      div_numer = div_sel_quo ? ACC_BITS'(rnd_w[ACC_BITS-1:FRAC_BITS])
                              : {{(DIV_NUM_BITS-SAMPLE_BITS-FRAC_BITS){1'b0}}, p_u,
                                 {FRAC_BITS{1'b0}}};
      div_denom = div_sel_quo ? DEN_BITS'(cfg.length) : DEN_BITS'(d_ff[D_BITS-2:0]);

      span_w = SPAN_BITS'(cfg.range_end) - SPAN_BITS'(cfg.range_start);
      if (!d_pos) begin
         frac_w = '0;
      end else if (div_quotient > FRAC_ONE) begin
         frac_w = FRAC_ONE[FRAC_BITS:0];
      end else begin
         frac_w = div_quotient[FRAC_BITS:0];
      end
      t_w = T_BITS'($signed({idx_ff, {FRAC_BITS{1'b0}}})) + $signed(T_BITS'(frac_w));

      mul_a  = mul_hi ? span_mag_ff[SPAN_BITS-1:SPAN_LO_BITS]
                      : SPAN_HI_BITS'(span_mag_ff[SPAN_LO_BITS-1:0]);
      prod_w = mul_a * t_mag_ff;

      rs_w = R_BITS'(cfg.range_start);
      qq_w = $signed(R_BITS'(div_quotient));
      r_w  = neg_ff ? rs_w - qq_w : rs_w + qq_w;

      p_in        = p_ff;
      d_in        = d_ff;
      idx_in      = idx_ff;
      st_in       = st_ff;
      fall_in     = fall_ff;
      span_neg_in = span_neg_ff;
      span_mag_in = span_mag_ff;
      neg_in      = neg_ff;
      t_mag_in    = t_mag_ff;
      prod_in     = prod_ff;
      acc_in      = acc_ff;
      out_st_in   = out_st_ff;
      out_pos_in  = out_pos_ff;
      out_fall_in = out_fall_ff;

      if (job_pop) begin
         p_in        = job_data[P_BITS-1:0];
         d_in        = job_data[P_BITS +: D_BITS];
         idx_in      = job_data[P_BITS+D_BITS +: INDEX_BITS];
         st_in       = job_data[P_BITS+D_BITS+INDEX_BITS +: STRENGTH_BITS];
         fall_in     = job_data[P_BITS+D_BITS+INDEX_BITS+STRENGTH_BITS];
         span_neg_in = span_w[SPAN_BITS-1];
         span_mag_in = span_w[SPAN_BITS-1] ? $unsigned(-span_w) : $unsigned(span_w);
      end
      if (load_frac) begin
         t_mag_in = t_w[T_BITS-1] ? $unsigned(-t_w) : $unsigned(t_w);
         neg_in   = span_neg_ff ^ t_w[T_BITS-1];
      end
      if (mul_lo || mul_hi) begin
         prod_in = prod_w;
      end
      if (mul_hi) begin
         acc_in = ACC_BITS'(prod_ff);
      end
      if (mul_sum) begin
         acc_in = acc_ff + ACC_BITS'({prod_ff, {SPAN_LO_BITS{1'b0}}});
      end
      if (load_out) begin
         out_st_in   = st_ff;
         out_fall_in = fall_ff;
         if (r_w > POS_MAX) begin
            out_pos_in = POS_MAX[POS_BITS-1:0];
         end else if (r_w < POS_MIN) begin
            out_pos_in = POS_MIN[POS_BITS-1:0];
         end else begin
            out_pos_in = r_w[POS_BITS-1:0];
         end
      end

      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff        <= p_in;
      d_ff        <= d_in;
      idx_ff      <= idx_in;
      st_ff       <= st_in;
      fall_ff     <= fall_in;
      span_neg_ff <= span_neg_in;
      span_mag_ff <= span_mag_in;
      neg_ff      <= neg_in;
      t_mag_ff    <= t_mag_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      out_st_ff   <= out_st_in;
      out_pos_ff  <= out_pos_in;
      out_fall_ff <= out_fall_in;
   end

endmodule

// ===== hdl/cefu_checker.sv =====
`include "assert_macros.svh"

module cefu_checker #(
   parameter int SAMPLE_BITS = cefu_pkg::SAMPLE_BITS_DEF
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic [((SAMPLE_BITS+7)/8)*8-1:0]    req_tdata,
   input logic                                req_tuser,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [cefu_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   input logic                                rsp_tuser
);
   import cefu_pkg::*;

   logic                           req_stall, rsp_stall;
   logic [((SAMPLE_BITS+7)/8)*8:0] req_word;
   logic [RSP_DATA_BITS:0]         rsp_word;

   assign req_stall = req_tvalid && !req_tready;
   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign req_word  = {req_tuser, req_tdata};
   assign rsp_word  = {rsp_tuser, rsp_tdata};

   property p_rsp_hold;
      rsp_stall |=> rsp_tvalid && $stable(rsp_word);
   endproperty

   property p_req_hold;
      req_stall |=> req_tvalid && $stable(req_word);
   endproperty

   property p_strength_nonzero;
      rsp_tvalid |-> rsp_tdata[STRENGTH_BITS-1:0] != '0;
   endproperty

   property p_ready_falls;
      $fell(req_tready) |-> $past(req_tvalid);
   endproperty

   `CEFU_ASSERT(a_reset_drops_rsp, clock, reset |=> !rsp_tvalid, "response valid after reset")
   `CEFU_ASSERT_RST(a_rsp_hold, clock, reset, p_rsp_hold, "stalled response changed")
   `CEFU_ASSERT_RST(a_req_hold, clock, reset, p_req_hold, "stalled request changed")
   `CEFU_ASSERT_RST(a_strength_nonzero, clock, reset, p_strength_nonzero, "zero strength edge")
   `CEFU_ASSERT_RST(a_ready_falls_on_request, clock, reset, p_ready_falls, "ready fell unprompted")

endmodule

bind caliper_extremum_edge_finder_unit cefu_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_cefu_checker (.*);

// ===== sim/tb_top.sv =====
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import cefu_pkg::*;

   localparam int      DRAIN_CYCLES = 200;
   localparam int      ITEMS_PER_PHASE = 85;
   localparam int      RANDOM_PHASES = 6;
   localparam longint  TIMEOUT_NS = 5_000_000;
   localparam longint  POS_MAX = 64'sd2147483647;
   localparam longint  POS_MIN = -64'sd2147483648;
   localparam logic [1:0] PM_EITHER = 2'd3;

   typedef struct {
      logic [STRENGTH_BITS-1:0]   strength;
      logic signed [POS_BITS-1:0] position;
      logic                       falling;
   } edge_result_type;

   typedef enum {ROW_SAMPLE, ROW_REG} row_kind_type;

   typedef struct {
      row_kind_type       kind;
      csr_index_type      sel;
      logic [31:0]        value;
      logic               start;
      bit                 typed;
      edge_result_type    typed_res;
   } stim_row_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_tvalid = 1'b0;
   logic                         req_tready;
   logic [15:0]                  req_tdata = '0;
   logic                         req_tuser = 1'b0;
   logic                         rsp_tvalid;
   logic                         rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0]     rsp_tdata;
   logic                         rsp_tuser;
   logic                         csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0]    csr_index = '0;
   logic [CSR_DATA_BITS-1:0]     csr_wdata = '0;

   int send_idle_pct = 29;
   int recv_idle_pct = 50;
   int error_count = 0;

   // edge predictor state
   logic [THR_BITS-1:0] cfg_threshold = '0;
   logic [1:0]          cfg_polarity = PM_BOTH;
   logic                cfg_backward = 1'b0;
   logic [LEN_BITS-1:0] cfg_length = 13'd4096;
   longint              cfg_range_start = 0;
   longint              cfg_range_end = 65536;
   longint              cur_level = 0;
   longint              prev_level = 0;
   int                  pos_index = -1;
   int                  rise_run = -1;
   int                  drop_run = -1;
   int                  walk_level = 0;

   edge_result_type pending_edges[$];
   stim_row_type    directed_rows[$];

   caliper_extremum_edge_finder_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int eff_length();
      if (cfg_length == 0) return 1;
      if (cfg_length > MAX_SAMPLES) return MAX_SAMPLES;
      return int'(cfg_length);
   endfunction

   function automatic void set_register(csr_index_type sel, logic [31:0] val);
      case (sel)
         CSR_THRESHOLD:   cfg_threshold = val[THR_BITS-1:0];
         CSR_POLARITY:    cfg_polarity = val[1:0];
         CSR_BACKWARD:    cfg_backward = val[0];
         CSR_LENGTH:      cfg_length = val[LEN_BITS-1:0];
         CSR_RANGE_START: cfg_range_start = longint'($signed(val));
         CSR_RANGE_END:   cfg_range_end = longint'($signed(val));
         default: ;
      endcase
   endfunction

   function automatic logic signed [POS_BITS-1:0] interp_position(int idx, longint p, longint d);
      longint unsigned frac;
      longint unsigned den;
      longint unsigned mag;
      longint unsigned q;
      longint          t;
      longint          span;
      longint          num;
      longint          r;
      frac = 0;
      den = longint'(eff_length()) << FRAC_BITS;
      if (p < 0) p = 0;
      if (d > 0) frac = ($unsigned(p) << FRAC_BITS) / $unsigned(d);
      if (frac > (64'd1 << FRAC_BITS)) frac = 64'd1 << FRAC_BITS;
      t = longint'(idx) * (longint'(1) << FRAC_BITS) + $signed(frac);
      span = cfg_range_end - cfg_range_start;
      num = span * t;
      mag = (num < 0) ? $unsigned(-num) : $unsigned(num);
      q = (mag + den / 2) / den;
      r = (num < 0) ? cfg_range_start - $signed(q) : cfg_range_start + $signed(q);
      if (r > POS_MAX) r = POS_MAX;
      if (r < POS_MIN) r = POS_MIN;
      return r[POS_BITS-1:0];
   endfunction

   task automatic track_profile_sample(input logic signed [15:0] smp, input logic start,
                                       output bit hit, output edge_result_type res);
      longint                       s;
      longint                       thr;
      longint                       p;
      longint                       d;
      logic signed [INDEX_BITS-1:0] wrapped;
      int                           next_index;
      s = smp;
      thr = cfg_threshold;
      hit = 0;
      res = '{default: '0};
      if (start) begin
         cur_level = 0;
         prev_level = 0;
         rise_run = -1;
         drop_run = -1;
      end
      if (s < cur_level) begin
         if (cfg_polarity != PM_FALL_ONLY && rise_run > 0 && cur_level > thr) begin
            p = cur_level - prev_level;
            d = p + (cur_level - s);
            hit = 1;
            res.strength = 16'(cur_level);
            res.position = interp_position(pos_index, p, d);
            res.falling = KIND_RISE;
         end
         rise_run = 0;
         if (drop_run < 1) drop_run++;
      end else begin
         if (cfg_polarity != PM_RISE_ONLY && drop_run > 0 && cur_level < -thr) begin
            p = prev_level - cur_level;
            d = p + (s - cur_level);
            hit = 1;
            res.strength = 16'(-cur_level);
            res.position = interp_position(pos_index, p, d);
            res.falling = KIND_FALL;
         end
         if (rise_run < 1) rise_run++;
         drop_run = 0;
      end
      if (start || pos_index == -1) begin
         next_index = (cfg_backward == SCAN_REVERSE) ? eff_length() - 1 : 0;
      end else begin
         wrapped = INDEX_BITS'(pos_index + ((cfg_backward == SCAN_REVERSE) ? -1 : 1));
         next_index = wrapped;
      end
      prev_level = cur_level;
      cur_level = s;
      pos_index = next_index;
   endtask

   task automatic report_mismatch(string what);
      $display("%0t rsp mismatch: %s", $time, what);
      error_count++;
   endtask

   task automatic check_result(logic [RSP_DATA_BITS-1:0] data, logic falling_bit);
      edge_result_type want;
      if (pending_edges.size() == 0) begin
         report_mismatch($sformatf("unexpected edge strength %0d position %0d falling %0b",
                                   data[15:0], $signed(data[47:16]), falling_bit));
         return;
      end
      want = pending_edges.pop_front();
      if (data[15:0] !== want.strength)
         report_mismatch($sformatf("strength %0d, want %0d", data[15:0], want.strength));
      if ($signed(data[47:16]) !== want.position)
         report_mismatch($sformatf("position %0d, want %0d", $signed(data[47:16]),
                                   want.position));
      if (falling_bit !== want.falling)
         report_mismatch($sformatf("falling %0b, want %0b", falling_bit, want.falling));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_result(rsp_tdata, rsp_tuser);
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic send_request(logic signed [15:0] smp, logic start);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= smp;
      req_tuser <= start;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic issue_sample(logic signed [15:0] smp, logic start, bit typed,
                               edge_result_type typed_res);
      bit              hit;
      edge_result_type res;
      send_request(smp, start);
      track_profile_sample(smp, start, hit, res);
      if (typed) pending_edges.push_back(typed_res);
      else if (hit) pending_edges.push_back(res);
   endtask

   // drop valid, let every edge arrive and the back end drain
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_edges.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic apply_register(csr_index_type sel, logic [31:0] val);
      csr_we <= 1'b1;
      csr_index <= sel;
      csr_wdata <= val;
      set_register(sel, val);
      @(posedge clock);
   endtask

   function automatic void add_sample(logic signed [15:0] smp, logic start);
      directed_rows.push_back('{ROW_SAMPLE, CSR_THRESHOLD, 32'(smp), start, 1'b0,
                                '{default: '0}});
   endfunction

   function automatic void add_typed(logic signed [15:0] smp, logic start,
                                     edge_result_type res);
      directed_rows.push_back('{ROW_SAMPLE, CSR_THRESHOLD, 32'(smp), start, 1'b1, res});
   endfunction

   function automatic void add_reg(csr_index_type sel, logic [31:0] val);
      directed_rows.push_back('{ROW_REG, sel, val, 1'b0, 1'b0, '{default: '0}});
   endfunction

   function automatic logic [31:0] pick_register(csr_index_type sel);
      case (sel)
         CSR_THRESHOLD: begin
            case ($urandom_range(5))
               0: return 0;
               1: return 32767;
               2: return $urandom_range(0, 32767);
               default: return $urandom_range(0, 3000);
            endcase
         end
         CSR_POLARITY: return $urandom_range(0, 3);
         CSR_BACKWARD: return $urandom_range(0, 1);
         CSR_LENGTH: begin
            case ($urandom_range(5))
               0: return 0;
               1: return $urandom_range(MAX_SAMPLES + 1, 8191);
               2: return MAX_SAMPLES;
               3: return $urandom_range(1, MAX_SAMPLES);
               default: return $urandom_range(1, 16);
            endcase
         end
         default: begin
            case ($urandom_range(3))
               0: return 32'h8000_0000;
               1: return 32'h7fff_ffff;
               2: return $urandom;
               default: return $urandom_range(0, 1 << 22);
            endcase
         end
      endcase
   endfunction

   // mostly a random walk with peaks, plus rails, repeats and noise
   function automatic logic signed [15:0] next_level();
      int r;
      int step;
      r = $urandom_range(99);
      if (r < 10) begin
         walk_level = $signed(16'($urandom));
      end else if (r < 20) begin
         case ($urandom_range(3))
            0: walk_level = -32768;
            1: walk_level = 32767;
            2: walk_level = 0;
            default: walk_level = -1;
         endcase
      end else if (r >= 30) begin
         step = int'($urandom_range(0, 24000)) - 12000;
         walk_level += step;
         if (walk_level > 32767) walk_level = 32767;
         if (walk_level < -32768) walk_level = -32768;
      end
      return 16'(walk_level);
   endfunction

   initial begin
      #(TIMEOUT_NS);
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      edge_result_type none;
      bit              reg_open;
      int              ph;
      int              n;
      int              left;
      logic            start;

      none = '{default: '0};
      reg_open = 0;

      add_sample(16'sd0, 1'b0);
      add_sample(16'sd32767, 1'b0);
      add_typed(16'sd0, 1'b0, '{16'd32767, 32'sd24, KIND_RISE});
      add_sample(-16'sd32768, 1'b0);
      add_typed(16'sd0, 1'b0, '{16'd32768, 32'sd56, KIND_FALL});
      add_sample(16'sd0, 1'b0);
      add_sample(16'sd100, 1'b1);
      add_sample(16'sd200, 1'b0);
      add_sample(16'sd200, 1'b0);
      add_sample(16'sd50, 1'b0);
      add_reg(CSR_THRESHOLD, 32'd32767);
      add_reg(CSR_POLARITY, 32'(PM_EITHER));
      add_reg(CSR_BACKWARD, 32'(SCAN_REVERSE));
      add_reg(CSR_LENGTH, 32'd0);
      add_reg(CSR_RANGE_START, 32'h8000_0000);
      add_reg(CSR_RANGE_END, 32'h7fff_ffff);
      add_sample(-16'sd100, 1'b1);
      add_sample(-16'sd32768, 1'b0);
      add_sample(16'sd32767, 1'b0);
      add_sample(16'sd32767, 1'b0);
      add_sample(-16'sd5, 1'b0);
      add_reg(CSR_THRESHOLD, 32'd0);
      add_reg(CSR_POLARITY, 32'(PM_RISE_ONLY));
      add_reg(CSR_BACKWARD, 32'd0);
      add_reg(CSR_LENGTH, 32'd8191);
      add_reg(CSR_RANGE_START, 32'h7fff_ffff);
      add_reg(CSR_RANGE_END, 32'h8000_0000);
      add_sample(16'sd10, 1'b1);
      add_sample(-16'sd10, 1'b0);
      add_sample(16'sd20, 1'b0);
      add_sample(16'sd5, 1'b0);
      add_reg(CSR_POLARITY, 32'(PM_FALL_ONLY));
      add_reg(CSR_LENGTH, 32'(MAX_SAMPLES));
      add_sample(-16'sd3000, 1'b0);
      add_sample(16'sd1000, 1'b0);
      add_sample(16'sd2000, 1'b0);
      add_sample(16'sd0, 1'b0);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_REG) begin
            if (!reg_open) begin
               settle();
               reg_open = 1;
            end
            apply_register(directed_rows[i].sel, directed_rows[i].value);
         end else begin
            if (reg_open) begin
               csr_we <= 1'b0;
               reg_open = 0;
            end
            issue_sample(directed_rows[i].value[15:0], directed_rows[i].start,
                         directed_rows[i].typed, directed_rows[i].typed_res);
         end
      end

      for (ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph / 2)
            0: begin
               send_idle_pct = 29;
               recv_idle_pct = 50;
            end
            1: begin
               send_idle_pct = 50;
               recv_idle_pct = 29;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         settle();
         apply_register(CSR_THRESHOLD, pick_register(CSR_THRESHOLD));
         apply_register(CSR_POLARITY, pick_register(CSR_POLARITY));
         apply_register(CSR_BACKWARD, pick_register(CSR_BACKWARD));
         apply_register(CSR_LENGTH, pick_register(CSR_LENGTH));
         apply_register(CSR_RANGE_START, pick_register(CSR_RANGE_START));
         apply_register(CSR_RANGE_END, pick_register(CSR_RANGE_END));
         csr_we <= 1'b0;
         left = 0;
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (ph == 2 && n == ITEMS_PER_PHASE / 2) begin
               // hold requests until every pending edge is out
               req_tvalid <= 1'b0;
               do @(posedge clock); while (pending_edges.size() != 0);
            end
            if (left == 0) begin
               start = 1'b1;
               left = ($urandom_range(9) == 0) ? $urandom_range(40, 80) : $urandom_range(4, 30);
            end else begin
               start = ($urandom_range(99) < 3);
            end
            left--;
            issue_sample(next_level(), start, 1'b0, none);
         end
      end

      settle();
      if (error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
